// ===== rtl/wspf_pkg.sv =====
// shared types and constants of the weighted-sum peak finder
package wspf_pkg;

   // field widths fixed by the item format
   localparam int SAMPLE_FIELD_W = 16;
   localparam int ET_W           = 10;
   localparam int BIN_W          = 4;
   localparam int IDX_W          = 6;
   localparam int WEIGHT_W       = 10;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [ET_W-1:0]  ET_MAX  = 10'h3FF;
   localparam logic [IDX_W-1:0] IDX_SAT = 6'd63;

   typedef logic signed [WEIGHT_W-1:0] wspf_weight_type;

   // register indexes of the control port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_0       = 3'd0,
      CSR_WEIGHT_1       = 3'd1,
      CSR_WEIGHT_2       = 3'd2,
      CSR_WEIGHT_3       = 3'd3,
      CSR_PEAK_ENABLE    = 3'd4,
      CSR_PEAK_THRESHOLD = 3'd5,
      CSR_ALIGN_OFFSET   = 3'd6,
      CSR_OUTPUT_COUNT   = 3'd7
   } wspf_csr_type;

   // register reset values
   localparam wspf_weight_type WEIGHT_0_RST = 10'sd256;
   localparam wspf_weight_type WEIGHT_1_RST = 10'sd256;
   localparam wspf_weight_type WEIGHT_2_RST = 10'sd0;
   localparam wspf_weight_type WEIGHT_3_RST = 10'sd0;
   localparam logic              PEAK_ENABLE_RST = 1'b1;
   localparam logic [15:0]       PEAK_THRESHOLD_RST = 16'd0;
   localparam logic [BIN_W-1:0]  ALIGN_OFFSET_RST = 4'd2;
   localparam logic [BIN_W-1:0]  OUTPUT_COUNT_RST = 4'd4;

   // per-bin control that travels alongside the tap samples
   typedef struct packed {
      logic              peak_ok;  // sum may be shown (peak found or peak test off)
      logic              pegged;   // center sample above the output range
      logic              fine;
      logic [BIN_W-1:0]  bin;
      logic              last;
   } wspf_ctl_type;

endpackage

// ===== rtl/wspf_req_if.sv =====
// input channel: one tower sample per item
interface wspf_req_if
   import wspf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [SAMPLE_FIELD_W-1:0] sample_value;
   logic                      fine_bit;
   logic                      frame_start;

   modport source (output valid, sample_value, fine_bit, frame_start, input ready);
   modport sink   (input valid, sample_value, fine_bit, frame_start, output ready);
endinterface

// ===== rtl/wspf_rsp_if.sv =====
// result channel: one output bin per item
interface wspf_rsp_if
   import wspf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ET_W-1:0]  tp_et;
   logic             fine_grain;
   logic [BIN_W-1:0] bin_index;
   logic             last_bin;

   modport source (output valid, tp_et, fine_grain, bin_index, last_bin, input ready);
   modport sink   (input valid, tp_et, fine_grain, bin_index, last_bin, output ready);
endinterface

// ===== rtl/wspf_sum.sv =====
// weighted sum datapath: tap products, sum, clamp and result register
module wspf_sum
   import wspf_pkg::*;
#(
   parameter int NUM_TAPS = 2,
   parameter int SAMPLE_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SAMPLE_W-1:0] in_tap [NUM_TAPS],
   input  wspf_ctl_type      in_ctl,
   input  wspf_weight_type   weight [4],
   wspf_rsp_if.source        rsp_ch
);

   localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
   localparam int TERM_W = PROD_W - 8;
   localparam int SUM_W  = TERM_W + 2;

   logic                     prod_valid_ff;
   logic signed [TERM_W-1:0] term_ff [NUM_TAPS];
   logic signed [TERM_W-1:0] term_in [NUM_TAPS];
   wspf_ctl_type             prod_ctl_ff;
   logic                     prod_ready;

   logic                     out_valid_ff;
   logic [ET_W-1:0]          et_ff;
   logic [ET_W-1:0]          et_in;
   logic                     fine_ff;
   logic [BIN_W-1:0]         bin_ff;
   logic                     last_ff;
   logic                     out_ready;

   logic signed [SUM_W-1:0]  sum;
   logic [ET_W-1:0]          clamped;

   assign out_ready  = !out_valid_ff || rsp_ch.ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign in_ready   = prod_ready;

   // tap products, each truncated toward zero after the signed Q2.8 weight scale
   always_comb begin
      logic signed [PROD_W-1:0] tap_s;
      logic signed [PROD_W-1:0] w_s;
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] adj;
      for (int t = 0; t < NUM_TAPS; t++) begin
         tap_s = {{(PROD_W-SAMPLE_W){1'b0}}, in_tap[t]};
         w_s   = {{(PROD_W-WEIGHT_W){weight[t][WEIGHT_W-1]}}, weight[t]};
         prod  = tap_s * w_s;
         adj   = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
         term_in[t] = adj[PROD_W-1:8];
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         prod_valid_ff <= in_valid;
      end
      if (prod_ready && in_valid) begin
         term_ff     <= term_in;
         prod_ctl_ff <= in_ctl;
      end
   end

   // sum of terms and clamp to the output range; pegged bins show full scale, bins without a peak show zero
   always_comb begin
      sum = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         sum = sum + {{(SUM_W-TERM_W){term_ff[t][TERM_W-1]}}, term_ff[t]};
      end
      if (sum[SUM_W-1]) begin
         clamped = '0;
      end else if ($unsigned(sum) > SUM_W'(ET_MAX)) begin
         clamped = ET_MAX;
      end else begin
         clamped = sum[ET_W-1:0];
      end
      if (prod_ctl_ff.pegged) begin
         et_in = ET_MAX;
      end else if (!prod_ctl_ff.peak_ok) begin
         et_in = '0;
      end else begin
         et_in = clamped;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= prod_valid_ff;
      end
      if (out_ready && prod_valid_ff) begin
         et_ff   <= et_in;
         fine_ff <= prod_ctl_ff.fine && prod_ctl_ff.peak_ok;
         bin_ff  <= prod_ctl_ff.bin;
         last_ff <= prod_ctl_ff.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.tp_et      = et_ff;
   assign rsp_ch.fine_grain = fine_ff;
   assign rsp_ch.bin_index  = bin_ff;
   assign rsp_ch.last_bin   = last_ff;

endmodule

// ===== rtl/weighted_sum_peak_finder_core.sv =====
// top level of the weighted-sum peak finder for one trigger tower
//
// Usage:
//   req_ch carries one linearized sample per item with its fine-grain bit and a
//   frame-start mark. rsp_ch carries at most one output bin per item: the bin
//   for frame sample i leaves with the item that carries sample i+L, where
//   L = max(NUM_TAPS-1, 1). Items outside the output window give no result. The
//   csr_ port writes one register per cycle; the user must write only while the
//   block is idle, which the block itself does not enforce.
// Throughput and stages:
//   one item per cycle sustained; a result passes the window/bin stage, loaded
//   as its item is accepted, then the product stage, and the sum and clamp land
//   in the result register. Every stage can take a new item in each cycle in
//   which it is free, so nothing but rsp_ch stalls slows it.
// Reset:
//   synchronous, clears the sample windows, the frame index and all stage
//   valids and loads the register defaults; the stream counts as a frame
//   begun at reset.
// Stall:
//   each stage holds while the one after it is full and stalled, so req_ch
//   stays ready as long as any stage has room.
module weighted_sum_peak_finder_core
   import wspf_pkg::*;
#(
   parameter int NUM_TAPS    = 2,
   parameter int MAX_FRAME   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   wspf_req_if.sink               req_ch,
   wspf_rsp_if.source             rsp_ch
);

   localparam int SampleW   = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
   localparam int Lookahead = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;

   // control registers
   wspf_weight_type        weight_ff [4];
   logic                   peak_enable_ff;
   logic [15:0]            peak_threshold_ff;
   logic [BIN_W-1:0]       align_offset_ff;
   logic [BIN_W-1:0]       output_count_ff;

   // sample history and frame index
   logic [SampleW-1:0]     win_ff [4];
   logic                   fwin_ff [4];
   logic [IDX_W-1:0]       index_ff;
   logic [IDX_W-1:0]       index_in;

   // first stage
   logic                   s1_valid_ff;
   logic [SampleW-1:0]     s1_tap_ff [NUM_TAPS];
   logic [SampleW-1:0]     s1_tap_in [NUM_TAPS];
   wspf_ctl_type           s1_ctl_ff;
   wspf_ctl_type           s1_ctl_in;
   logic                   emit_in;
   logic                   s2_ready;
   logic                   req_fire;

   logic [SampleW-1:0]     s [5];
   logic                   f [5];
   logic [IDX_W-1:0]       n;

   assign req_ch.ready = !s1_valid_ff || s2_ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0]      <= WEIGHT_0_RST;
         weight_ff[1]      <= WEIGHT_1_RST;
         weight_ff[2]      <= WEIGHT_2_RST;
         weight_ff[3]      <= WEIGHT_3_RST;
         peak_enable_ff    <= PEAK_ENABLE_RST;
         peak_threshold_ff <= PEAK_THRESHOLD_RST;
         align_offset_ff   <= ALIGN_OFFSET_RST;
         output_count_ff   <= OUTPUT_COUNT_RST;
      end else if (csr_we) begin
         case (wspf_csr_type'(csr_index))
            CSR_WEIGHT_0:       weight_ff[0] <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_1:       weight_ff[1] <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_2:       weight_ff[2] <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_3:       weight_ff[3] <= csr_wdata[WEIGHT_W-1:0];
            CSR_PEAK_ENABLE:    peak_enable_ff <= csr_wdata[0];
            CSR_PEAK_THRESHOLD: peak_threshold_ff <= csr_wdata[15:0];
            CSR_ALIGN_OFFSET:   align_offset_ff <= csr_wdata[BIN_W-1:0];
            CSR_OUTPUT_COUNT:   output_count_ff <= csr_wdata[BIN_W-1:0];
            default: ;
         endcase
      end
   end

   // current sample and the window as seen by this item (cleared at frame start)
   always_comb begin
      s[0] = req_ch.sample_value[SampleW-1:0];
      f[0] = req_ch.fine_bit;
      for (int k = 0; k < 4; k++) begin
         s[k+1] = req_ch.frame_start ? '0 : win_ff[k];
         f[k+1] = req_ch.frame_start ? 1'b0 : fwin_ff[k];
      end
      n        = req_ch.frame_start ? '0 : index_ff;
      index_in = (n < IDX_SAT) ? n + 1'b1 : IDX_SAT;
   end

   // output window decision, peak test and tap selection
   always_comb begin
      logic [IDX_W-1:0]   idx;
      logic [IDX_W-1:0]   win_end;
      logic [IDX_W-1:0]   bin_full;
      logic [SampleW-1:0] cur;
      logic               peak;
      idx      = n - IDX_W'(Lookahead);
      win_end  = IDX_W'(align_offset_ff) + IDX_W'(output_count_ff);
      bin_full = idx - IDX_W'(align_offset_ff);
      emit_in  = (n >= IDX_W'(Lookahead)) && ({1'b0, n} < (IDX_W+1)'(MAX_FRAME))
                 && (output_count_ff != '0)
                 && (idx >= IDX_W'(align_offset_ff)) && (idx < win_end);
      cur  = s[Lookahead];
      peak = (cur > s[Lookahead+1]) && (cur >= s[Lookahead-1])
             && (16'(cur) > peak_threshold_ff);
      s1_ctl_in.peak_ok = !peak_enable_ff || peak;
      s1_ctl_in.pegged  = (SampleW'(ET_MAX) < cur);
      s1_ctl_in.fine    = f[Lookahead];
      s1_ctl_in.bin     = bin_full[BIN_W-1:0];
      s1_ctl_in.last    = ((BIN_W+1)'(bin_full[BIN_W-1:0]) + 1'b1)
                          == (BIN_W+1)'(output_count_ff);
      for (int t = 0; t < NUM_TAPS; t++) begin
         s1_tap_in[t] = s[Lookahead-t];
      end
   end

   // window shift and frame index
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            win_ff[k]  <= '0;
            fwin_ff[k] <= 1'b0;
         end
         index_ff <= '0;
      end else if (req_fire) begin
         for (int k = 0; k < 4; k++) begin
            win_ff[k]  <= s[k];
            fwin_ff[k] <= f[k];
         end
         index_ff <= index_in;
      end
   end

   // first stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= emit_in;
      end else if (s2_ready) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         s1_tap_ff <= s1_tap_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   wspf_sum #(
      .NUM_TAPS (NUM_TAPS),
      .SAMPLE_W (SampleW)
   ) u_sum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (s2_ready),
      .in_tap   (s1_tap_ff),
      .in_ctl   (s1_ctl_ff),
      .weight   (weight_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule
